// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks the property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication: once cond holds, expect holds on the following clock edge.
`define ASSERT_NEXT(lbl, cond, expect_q, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expect_q)) \
      else $error(msg);

`endif

// ----- rtl/core/mpeg2iq_pkg.sv -----
// ----------------------------------------------------------------------------
// mpeg2iq_pkg
// Shared types, constants and scan tables of the inverse quant / scan block.
// ----------------------------------------------------------------------------
package mpeg2iq_pkg;

   localparam int unsigned LVL_W  = 12;
   localparam int unsigned IDX_W  = 6;
   localparam int unsigned POS_W  = 7;
   localparam int unsigned PROD_W = 31;

   localparam logic [POS_W-1:0] POS_LAST  = 7'd63;
   localparam logic [POS_W-1:0] POS_SAT   = 7'd64;
   localparam logic [IDX_W-1:0] IDX_LAST  = 6'd63;

   localparam logic FUNC_WEIGHT = 1'b0;
   localparam logic FUNC_PAIR   = 1'b1;

   localparam logic CSR_ALT_SCAN = 1'b0;
   localparam logic CSR_DC_PREC  = 1'b1;

   localparam logic signed [PROD_W-1:0] CLIP_MIN = -31'sd2048;
   localparam logic signed [PROD_W-1:0] CLIP_MAX = 31'sd2047;

   localparam logic [IDX_W-1:0] ZZ_ORDER [64] = '{
      6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
      6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
      6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
      6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
      6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
      6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
      6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
      6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
   };

   localparam logic [IDX_W-1:0] ALT_ORDER [64] = '{
      6'd0,  6'd8,  6'd16, 6'd24, 6'd1,  6'd9,  6'd2,  6'd10,
      6'd17, 6'd25, 6'd32, 6'd40, 6'd48, 6'd56, 6'd57, 6'd49,
      6'd41, 6'd33, 6'd26, 6'd18, 6'd3,  6'd11, 6'd4,  6'd12,
      6'd19, 6'd27, 6'd34, 6'd42, 6'd50, 6'd58, 6'd35, 6'd43,
      6'd51, 6'd59, 6'd20, 6'd28, 6'd5,  6'd13, 6'd6,  6'd14,
      6'd21, 6'd29, 6'd36, 6'd44, 6'd52, 6'd60, 6'd37, 6'd45,
      6'd53, 6'd61, 6'd22, 6'd30, 6'd7,  6'd15, 6'd23, 6'd31,
      6'd38, 6'd46, 6'd54, 6'd62, 6'd39, 6'd47, 6'd55, 6'd63
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_STORE,
      ST_DRAIN_RD,
      ST_DRAIN_OUT
   } state_type;

   typedef struct packed {
      logic wr_weight;  // weight load transaction
      logic pair_load;  // capture a run-level pair, start weight read
      logic mul1;       // level term times weight
      logic mul2;       // times quantiser scale
      logic store;      // scale, clip, write coefficient
      logic drain_rd;   // read coefficient at drain counter
      logic advance;    // result taken, step drain counter
      logic clear;      // end of block, reset block state
   } cmd_type;

   typedef struct packed {
      logic eob;        // captured pair ends the block
      logic cnt_last;   // drain counter at final coefficient
   } status_type;

   function automatic logic signed [LVL_W-1:0] clip12(input logic signed [PROD_W-1:0] v);
      logic signed [LVL_W-1:0] r;
      if (v < CLIP_MIN) begin
         r = -12'sd2048;
      end else if (v > CLIP_MAX) begin
         r = 12'sd2047;
      end else begin
         r = v[LVL_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/mpeg2iq_ctrl.sv -----
// ----------------------------------------------------------------------------
// mpeg2iq_ctrl
// Sequencer: accepts transactions, steps the dequantizer, drains the block.
// ----------------------------------------------------------------------------
module mpeg2iq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_func,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mpeg2iq_pkg::status_type status,
   output mpeg2iq_pkg::cmd_type    cmd
);

   mpeg2iq_pkg::state_type state_ff, state_in;
   logic                   req_fire;
   logic                   rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpeg2iq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpeg2iq_pkg::ST_IDLE: begin
            if (req_fire && (req_func == mpeg2iq_pkg::FUNC_PAIR)) begin
               state_in = mpeg2iq_pkg::ST_MUL1;
            end
         end
         mpeg2iq_pkg::ST_MUL1:  state_in = mpeg2iq_pkg::ST_MUL2;
         mpeg2iq_pkg::ST_MUL2:  state_in = mpeg2iq_pkg::ST_STORE;
         mpeg2iq_pkg::ST_STORE: begin
            state_in = status.eob ? mpeg2iq_pkg::ST_DRAIN_RD : mpeg2iq_pkg::ST_IDLE;
         end
         mpeg2iq_pkg::ST_DRAIN_RD: state_in = mpeg2iq_pkg::ST_DRAIN_OUT;
         mpeg2iq_pkg::ST_DRAIN_OUT: begin
            if (rsp_fire) begin
               state_in = status.cnt_last ? mpeg2iq_pkg::ST_IDLE
                                          : mpeg2iq_pkg::ST_DRAIN_RD;
            end
         end
         default: state_in = mpeg2iq_pkg::ST_IDLE;
      endcase
   end

   // ready/valid are constant high in their states, so the handshake reduces
   // to the other side's signal here
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         mpeg2iq_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.wr_weight = req_valid && (req_func == mpeg2iq_pkg::FUNC_WEIGHT);
            cmd.pair_load = req_valid && (req_func == mpeg2iq_pkg::FUNC_PAIR);
         end
         mpeg2iq_pkg::ST_MUL1:     cmd.mul1     = 1'b1;
         mpeg2iq_pkg::ST_MUL2:     cmd.mul2     = 1'b1;
         mpeg2iq_pkg::ST_STORE:    cmd.store    = 1'b1;
         mpeg2iq_pkg::ST_DRAIN_RD: cmd.drain_rd = 1'b1;
         mpeg2iq_pkg::ST_DRAIN_OUT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready;
            cmd.clear   = rsp_ready && status.cnt_last;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- rtl/core/mpeg2iq_dp.sv -----
// ----------------------------------------------------------------------------
// mpeg2iq_dp
// Datapath: weight and coefficient memories, scan lookup, dequantizer.
// ----------------------------------------------------------------------------
module mpeg2iq_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  mpeg2iq_pkg::cmd_type    cmd,
   output mpeg2iq_pkg::status_type status,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [1:0]              csr_wdata,
   input  logic                    req_intra,
   input  logic [5:0]              req_weight_index,
   input  logic [7:0]              req_weight,
   input  logic [5:0]              req_run,
   input  logic signed [11:0]      req_level,
   input  logic [6:0]              req_quant_scale,
   input  logic                    req_end_of_block,
   output logic [5:0]              rsp_coef_index,
   output logic signed [11:0]      rsp_coef_value,
   output logic                    rsp_last,
   output logic                    rsp_overflow
);

   // configuration
   logic       alt_ff;
   logic [1:0] prec_ff;

   // block state
   logic [6:0]  scan_pos_ff;
   logic        parity_ff;
   logic        blk_start_ff;
   logic        ovf_seen_ff;
   logic [63:0] vld_ff;
   logic [5:0]  cnt_ff;

   // memories
   logic [7:0]  wmem [128];
   logic [11:0] cmem [64];

   // captured pair
   logic [7:0]         w_ff;
   logic signed [11:0] lvl_ff;
   logic [6:0]         q_ff;
   logic               intra_ff;
   logic               eob_ff;
   logic               dc_ff;
   logic               ovf_ff;
   logic [5:0]         raster_ff;
   logic [6:0]         next_pos_ff;

   logic signed [22:0] prod1_ff;
   logic signed [30:0] prod2_ff;

   logic [11:0] crd_ff;
   logic        vrd_ff;

   // pair decode at accept
   logic [6:0] pos_sum;
   logic       dc_hit;
   logic       ovf_hit;
   logic [5:0] scan_idx;
   logic [5:0] raster;

   assign pos_sum  = scan_pos_ff + {1'b0, req_run};
   assign dc_hit   = blk_start_ff && req_intra && (req_run == 6'd0);
   assign ovf_hit  = !dc_hit && (pos_sum > mpeg2iq_pkg::POS_LAST);
   assign scan_idx = dc_hit ? 6'd0 : pos_sum[5:0];
   assign raster   = alt_ff ? mpeg2iq_pkg::ALT_ORDER[scan_idx]
                            : mpeg2iq_pkg::ZZ_ORDER[scan_idx];

   // level term: level for intra, 2*level+sign otherwise
   logic signed [13:0] sgn;
   logic signed [13:0] m_val;

   always_comb begin
      if (lvl_ff > 12'sd0) begin
         sgn = 14'sd1;
      end else if (lvl_ff < 12'sd0) begin
         sgn = -14'sd1;
      end else begin
         sgn = 14'sd0;
      end
      if (intra_ff) begin
         m_val = {{2{lvl_ff[11]}}, lvl_ff};
      end else begin
         m_val = $signed({lvl_ff[11], lvl_ff, 1'b0}) + sgn;
      end
   end

   // scale down toward zero, then clip; DC path is a plain shift
   logic signed [30:0] adj;
   logic signed [30:0] quot;
   logic signed [30:0] dc_wide;
   logic signed [11:0] new_val;

   always_comb begin
      if (prod2_ff[30]) begin
         adj = prod2_ff + (intra_ff ? 31'sd15 : 31'sd31);
      end else begin
         adj = prod2_ff;
      end
      quot    = intra_ff ? (adj >>> 4) : (adj >>> 5);
      dc_wide = $signed({{19{lvl_ff[11]}}, lvl_ff}) <<< (2'd3 - prec_ff);
      new_val = dc_ff ? mpeg2iq_pkg::clip12(dc_wide) : mpeg2iq_pkg::clip12(quot);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alt_ff       <= 1'b0;
         prec_ff      <= 2'd0;
         scan_pos_ff  <= '0;
         parity_ff    <= 1'b0;
         blk_start_ff <= 1'b1;
         ovf_seen_ff  <= 1'b0;
         vld_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == mpeg2iq_pkg::CSR_ALT_SCAN) begin
               alt_ff <= csr_wdata[0];
            end else begin
               prec_ff <= csr_wdata;
            end
         end
         if (cmd.pair_load) begin
            blk_start_ff <= 1'b0;
            if (ovf_hit) begin
               ovf_seen_ff <= 1'b1;
            end
         end
         if (cmd.store) begin
            scan_pos_ff <= next_pos_ff;
            if (!ovf_ff) begin
               vld_ff[raster_ff] <= 1'b1;
               parity_ff         <= parity_ff ^ new_val[0];
            end
         end
         if (cmd.advance) begin
            cnt_ff <= cnt_ff + 6'd1;
         end
         if (cmd.clear) begin
            scan_pos_ff  <= '0;
            parity_ff    <= 1'b0;
            blk_start_ff <= 1'b1;
            ovf_seen_ff  <= 1'b0;
            vld_ff       <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.wr_weight) begin
         wmem[{req_intra, req_weight_index}] <= req_weight;
      end
      if (cmd.pair_load) begin
         w_ff        <= wmem[{req_intra, raster}];
         lvl_ff      <= req_level;
         q_ff        <= req_quant_scale;
         intra_ff    <= req_intra;
         eob_ff      <= req_end_of_block;
         dc_ff       <= dc_hit;
         ovf_ff      <= ovf_hit;
         raster_ff   <= raster;
         next_pos_ff <= dc_hit  ? 7'd1 :
                        ovf_hit ? mpeg2iq_pkg::POS_SAT : (pos_sum + 7'd1);
      end
      if (cmd.mul1) begin
         prod1_ff <= m_val * $signed({1'b0, w_ff});
      end
      if (cmd.mul2) begin
         prod2_ff <= prod1_ff * $signed({1'b0, q_ff});
      end
      if (cmd.store && !ovf_ff) begin
         cmem[raster_ff] <= new_val;
      end
      if (cmd.drain_rd) begin
         crd_ff <= cmem[cnt_ff];
         vrd_ff <= vld_ff[cnt_ff];
      end
   end

   assign status.eob      = eob_ff;
   assign status.cnt_last = (cnt_ff == mpeg2iq_pkg::IDX_LAST);

   // mismatch control flips the LSB of the last coefficient on even parity
   assign rsp_coef_index = cnt_ff;
   assign rsp_last       = status.cnt_last;
   assign rsp_overflow   = ovf_seen_ff;
   assign rsp_coef_value = $signed(vrd_ff ? crd_ff : 12'd0)
                           ^ $signed({11'd0, status.cnt_last && !parity_ff});

endmodule

// ----- rtl/core/mpeg2_inverse_quant_scan_top.sv -----
// ----------------------------------------------------------------------------
// mpeg2_inverse_quant_scan_top
// MPEG-2 inverse quantization and inverse scan of one 8x8 block.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel: weight loads (func 0) and run-level pairs (func 1).
//   A pair runs these steps before the next accept: weight memory read at
//   the accept edge, two multiplies (level term by weight, then by
//   quantiser scale), then scale/clip/store.
//   The end_of_block pair is followed by 64 rsp_* transactions in raster
//   order, each a coefficient memory read, then output; req_ready is low
//   for the whole drain.
//   A stalled rsp_ready holds the current coefficient; nothing is lost.
//   csr_* channel is always ready; index 0 selects alternate scan, index 1
//   the intra DC precision. Write only while the block is idle.
//   Reset clears configuration, scan state and the coefficient valid bits;
//   the weight memory holds garbage until loaded. No clearing pass is needed.
// ----------------------------------------------------------------------------
module mpeg2_inverse_quant_scan_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic               req_intra,
   input  logic [5:0]         req_weight_index,
   input  logic [7:0]         req_weight,
   input  logic [5:0]         req_run,
   input  logic signed [11:0] req_level,
   input  logic [6:0]         req_quant_scale,
   input  logic               req_end_of_block,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_coef_index,
   output logic signed [11:0] rsp_coef_value,
   output logic               rsp_last,
   output logic               rsp_overflow,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [1:0]         csr_wdata
);

   mpeg2iq_pkg::cmd_type    cmd;
   mpeg2iq_pkg::status_type status;

   assign csr_ready = 1'b1;

   mpeg2iq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mpeg2iq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_intra        (req_intra),
      .req_weight_index (req_weight_index),
      .req_weight       (req_weight),
      .req_run          (req_run),
      .req_level        (req_level),
      .req_quant_scale  (req_quant_scale),
      .req_end_of_block (req_end_of_block),
      .rsp_coef_index   (rsp_coef_index),
      .rsp_coef_value   (rsp_coef_value),
      .rsp_last         (rsp_last),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

// ----- rtl/core/mpeg2iq_checker.sv -----
// ----------------------------------------------------------------------------
// mpeg2iq_checker
// Port-level checks of the inverse quant / scan block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpeg2iq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [5:0]         rsp_coef_index,
   input logic signed [11:0] rsp_coef_value,
   input logic               rsp_last,
   input logic               rsp_overflow
);

   // stalled result keeps its position and value
   `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_coef_index) && $stable(rsp_coef_value), "rsp changed while stalled")

   `ASSERT_CLK(a_last_pos, !rsp_valid || (rsp_last == (rsp_coef_index == 6'd63)), "last flag not on coefficient 63")

   // no new transaction while a block is draining
   `ASSERT_CLK(a_no_req_in_drain, !(rsp_valid && req_valid && req_ready), "req accepted during drain")

   // drain walks raster order with a constant overflow flag
   `ASSERT_NEXT(a_drain_order, rsp_valid && rsp_ready && !rsp_last, !rsp_valid ##1 (rsp_valid && (rsp_coef_index == 6'($past(rsp_coef_index, 2) + 6'd1)) && (rsp_overflow == $past(rsp_overflow, 2))), "drain out of order")

endmodule

bind mpeg2_inverse_quant_scan_top mpeg2iq_checker u_mpeg2iq_checker (.*);
